// File: rtl/desa_pkg.sv
// Shared types, reset values and helpers of the double-ended stack allocator.
// No dependencies; used by rtl/double_ended_stack_allocator.sv.
`default_nettype none

package desa_pkg;

  // register reset values
  localparam logic [31:0] ArenaSizeReset   = 32'd65536;
  localparam logic [12:0] HeaderBytesReset = 13'd64;
  localparam logic [6:0]  MarkerBytesReset = 7'd16;

  // default sizing of the top level
  localparam int unsigned MarkerDepthDefault = 16;
  localparam int unsigned OffsetBitsDefault  = 32;

  // fixed field widths
  localparam int unsigned SizeW   = 32;
  localparam int unsigned AlignW  = 17;
  localparam int unsigned HeaderW = 13;
  localparam int unsigned MarkerW = 7;
  localparam int unsigned CfgIdxW = 2;

  // request codes
  typedef enum logic [1:0] {
    OpAlloc   = 2'd0,
    OpMark    = 2'd1,
    OpRelease = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgArenaSize   = 2'd0,
    CfgHeaderBytes = 2'd1,
    CfgMarkerBytes = 2'd2
  } cfg_idx_e;

  // alignment mask: largest power of two not above a, minus one (zero for 0 or 1)
  function automatic logic [AlignW-1:0] align_mask(input logic [AlignW-1:0] a);
    logic [AlignW-1:0] s;
    s = a;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s >> 1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/double_ended_stack_allocator.sv
// Double-ended stack allocator: request decode, side counters, marker stacks.
// Depends on rtl/desa_pkg.sv.
`default_nettype none

// One request is taken per clock cycle: start_i is accepted whenever it is high,
// busy_o stays low; unless a configuration register is written in the same cycle, the
// result shows on done_o and the result ports in the following cycle, for that cycle only.
// A request's whole work (alignment, space check, counter update and marker push
// or pop) is one pass through the logic between the input ports and the result
// registers, so a request sees the state left by the one before it. Each side's
// marker stack is a memory with a registered read that always holds the entry
// below the top, and the top itself sits in a register, so pops can follow each
// other every cycle. A write to any of the three configuration registers empties
// both sides and both marker stacks at once; there is no clearing pass after reset.
module double_ended_stack_allocator #(
  parameter int unsigned MarkerDepth = desa_pkg::MarkerDepthDefault,
  parameter int unsigned OffsetBits  = desa_pkg::OffsetBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [desa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  // request
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic                          side_i,
  input  wire logic [desa_pkg::AlignW-1:0]   align_i,
  input  wire logic [desa_pkg::SizeW-1:0]    size_i,
  // result
  output logic                               done_o,
  output logic                               ok_o,
  output logic [31:0]                        address_o,
  output logic [31:0]                        remaining_o,
  output logic                               arena_empty_o
);

  localparam int unsigned OB   = OffsetBits;
  localparam int unsigned CW   = ((OB > desa_pkg::SizeW) ? OB : desa_pkg::SizeW) + 2;
  localparam int unsigned CntW = $clog2(MarkerDepth + 1);
  localparam int unsigned AW   = (MarkerDepth > 1) ? $clog2(MarkerDepth) : 1;
  localparam logic [OB-1:0]   FreeReset =
    OB'(desa_pkg::ArenaSizeReset - 32'(desa_pkg::HeaderBytesReset));
  localparam logic [CntW-1:0] DepthCnt = CntW'(MarkerDepth);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  // configuration registers
  logic [31:0]                  arena_q, arena_d;
  logic [desa_pkg::HeaderW-1:0] header_q, header_d;
  logic [desa_pkg::MarkerW-1:0] marker_q, marker_d;
  logic                         reinit;

  // side state
  logic [OB-1:0]   l_used_q, l_used_d, r_used_q, r_used_d;
  logic [OB-1:0]   free_q, free_d;
  logic [CntW-1:0] l_cnt_q, l_cnt_d, r_cnt_q, r_cnt_d;

  // marker stacks: top entry in a register, entry below it read from memory
  logic [OB-1:0]   l_mem [MarkerDepth];
  logic [OB-1:0]   r_mem [MarkerDepth];
  logic [OB-1:0]   l_top_q, l_top_d, r_top_q, r_top_d;
  logic [OB-1:0]   l_below_q, r_below_q;
  logic            l_we, r_we;
  logic [AW-1:0]   l_ra, r_ra;

  // result registers
  logic          done_q, ok_q, empty_q;
  logic [31:0]   addr_q, rem_q;
  logic          ok_d;
  logic [31:0]   addr_d;

  // request datapath
  logic                        accept;
  logic [OB-1:0]               cur_used, cur_top, cur_below;
  logic [CntW-1:0]             cur_cnt;
  logic [desa_pkg::AlignW-1:0] m17, align_m1;
  logic [OB-1:0]               m_ob;
  logic [desa_pkg::SizeW-1:0]  blk_size;
  logic [OB-1:0]               blk_ob;
  logic [CW-1:0]               need;
  logic                        fits;
  logic [OB-1:0]               p_l, np_l, pad_l, p_r, np_r, pad_r, np_sel, pad_sel;
  logic [OB-1:0]               grant_used, grant_free;
  logic                        has_marker;
  logic [OB-1:0]               target, rel_free;
  logic                        grant, push, pop;
  logic [OB-1:0]               new_used, new_top;
  logic [CntW-1:0]             new_cnt;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // configuration decode
  always_comb begin
    arena_d  = arena_q;
    header_d = header_q;
    marker_d = marker_q;
    reinit   = 1'b0;
    if (cfg_we_i) begin
      unique case (desa_pkg::cfg_idx_e'(cfg_index_i))
        desa_pkg::CfgArenaSize: begin
          arena_d = cfg_data_i;
          reinit  = 1'b1;
        end
        desa_pkg::CfgHeaderBytes: begin
          header_d = cfg_data_i[desa_pkg::HeaderW-1:0];
          reinit   = 1'b1;
        end
        desa_pkg::CfgMarkerBytes: begin
          marker_d = cfg_data_i[desa_pkg::MarkerW-1:0];
          reinit   = 1'b1;
        end
        default: reinit = 1'b0;
      endcase
    end
  end

  // operands of the addressed side
  always_comb begin
    cur_used  = side_i ? r_used_q : l_used_q;
    cur_cnt   = side_i ? r_cnt_q : l_cnt_q;
    cur_top   = side_i ? r_top_q : l_top_q;
    cur_below = side_i ? r_below_q : l_below_q;
  end

  // space check and aligned placement
  always_comb begin
    m17      = desa_pkg::align_mask(align_i);
    m_ob     = OB'(m17);
    align_m1 = (align_i == '0) ? '0 : align_i - desa_pkg::AlignW'(1);
    blk_size = (op_i == desa_pkg::OpMark) ? desa_pkg::SizeW'(marker_q) : size_i;
    blk_ob   = OB'(blk_size);
    need     = CW'(blk_size) + CW'(align_m1);
    fits     = CW'(free_q) >= need;
    // left side rounds its free position up
    p_l      = OB'(header_q) + l_used_q;
    np_l     = (p_l + m_ob) & ~m_ob;
    pad_l    = np_l - p_l;
    // right side rounds the block start down
    p_r      = OB'(arena_q) - r_used_q - blk_ob;
    np_r     = p_r & ~m_ob;
    pad_r    = p_r - np_r;
    np_sel   = side_i ? np_r : np_l;
    pad_sel  = side_i ? pad_r : pad_l;
    grant_used = cur_used + blk_ob + pad_sel;
    grant_free = free_q - blk_ob - pad_sel;
  end

  // release target: last marker, or empty side
  always_comb begin
    has_marker = cur_cnt != '0;
    target     = has_marker ? cur_top : '0;
    if (target > cur_used) begin
      target = cur_used;
    end
    rel_free = free_q + (cur_used - target);
  end

  // request decode and next state
  always_comb begin
    grant    = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    ok_d     = 1'b0;
    addr_d   = '0;
    free_d   = free_q;
    new_used = cur_used;
    new_cnt  = cur_cnt;
    new_top  = cur_top;
    case (desa_pkg::op_e'(op_i))
      desa_pkg::OpAlloc: begin
        grant = fits;
      end
      desa_pkg::OpMark: begin
        grant = fits && (cur_cnt < DepthCnt);
        push  = grant;
      end
      desa_pkg::OpRelease: begin
        pop = 1'b1;
      end
      default: grant = 1'b0;
    endcase
    if (grant) begin
      ok_d     = 1'b1;
      addr_d   = 32'(np_sel);
      free_d   = grant_free;
      new_used = grant_used;
    end
    if (push) begin
      new_cnt = cur_cnt + OneCnt;
      new_top = cur_used;
    end
    if (pop) begin
      ok_d     = 1'b1;
      free_d   = rel_free;
      new_used = target;
      new_cnt  = has_marker ? cur_cnt - OneCnt : '0;
      new_top  = cur_below;
    end
    if (!accept) begin
      free_d = free_q;
    end
  end

  // per-side next values
  always_comb begin
    l_used_d = l_used_q;
    r_used_d = r_used_q;
    l_cnt_d  = l_cnt_q;
    r_cnt_d  = r_cnt_q;
    l_top_d  = l_top_q;
    r_top_d  = r_top_q;
    l_we     = 1'b0;
    r_we     = 1'b0;
    if (reinit) begin
      l_used_d = '0;
      r_used_d = '0;
      l_cnt_d  = '0;
      r_cnt_d  = '0;
    end else if (accept) begin
      if (side_i) begin
        r_used_d = new_used;
        r_cnt_d  = new_cnt;
        r_top_d  = new_top;
        r_we     = push;
      end else begin
        l_used_d = new_used;
        l_cnt_d  = new_cnt;
        l_top_d  = new_top;
        l_we     = push;
      end
    end
    // keep the entry below the new top ready for the next pop
    l_ra = (l_cnt_d > OneCnt) ? AW'(l_cnt_d - OneCnt - OneCnt) : '0;
    r_ra = (r_cnt_d > OneCnt) ? AW'(r_cnt_d - OneCnt - OneCnt) : '0;
  end

  // control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q  <= desa_pkg::ArenaSizeReset;
      header_q <= desa_pkg::HeaderBytesReset;
      marker_q <= desa_pkg::MarkerBytesReset;
      l_used_q <= '0;
      r_used_q <= '0;
      free_q   <= FreeReset;
      l_cnt_q  <= '0;
      r_cnt_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      arena_q  <= arena_d;
      header_q <= header_d;
      marker_q <= marker_d;
      l_used_q <= l_used_d;
      r_used_q <= r_used_d;
      l_cnt_q  <= l_cnt_d;
      r_cnt_q  <= r_cnt_d;
      done_q   <= accept && !reinit;
      if (reinit) begin
        free_q <= (arena_d >= 32'(header_d)) ? OB'(arena_d - 32'(header_d)) : '0;
      end else begin
        free_q <= free_d;
      end
    end
  end

  // marker stack memories and top registers
  always_ff @(posedge clk_i) begin
    if (l_we) begin
      l_mem[AW'(l_cnt_q)] <= l_used_q;
    end
    if (r_we) begin
      r_mem[AW'(r_cnt_q)] <= r_used_q;
    end
    l_below_q <= l_mem[l_ra];
    r_below_q <= r_mem[r_ra];
    l_top_q   <= l_top_d;
    r_top_q   <= r_top_d;
  end

  // result registers
  always_ff @(posedge clk_i) begin
    ok_q    <= ok_d;
    addr_q  <= addr_d;
    rem_q   <= 32'(free_d);
    empty_q <= (l_used_d == '0) && (r_used_d == '0);
  end

  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign address_o     = addr_q;
  assign remaining_o   = rem_q;
  assign arena_empty_o = empty_q;

  // marker counts stay within the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_cnt_q <= DepthCnt) && (r_cnt_q <= DepthCnt))
    else $error("marker count beyond stack depth");

  // every accepted item with no configuration write in its cycle gives one result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i) |=> done_o)
    else $error("accepted item without result strobe");

  // a refused request reports offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (address_o == '0))
    else $error("refused request with nonzero address");

  // empty flag agrees with the side counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (arena_empty_o == ((l_used_q == '0) && (r_used_q == '0))))
    else $error("arena_empty out of step with used counts");

  // a register write empties both marker stacks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_index_i == desa_pkg::CfgArenaSize ||
                  cfg_index_i == desa_pkg::CfgHeaderBytes ||
                  cfg_index_i == desa_pkg::CfgMarkerBytes))
    |=> ((l_cnt_q == '0) && (r_cnt_q == '0) && (l_used_q == '0) && (r_used_q == '0)))
    else $error("register write did not empty the arena");

endmodule

`default_nettype wire

// File: bench/allocator_checker.sv
// Checker of the double-ended stack allocator: mirrors the registers and both sides,
// predicts one result per accepted item and compares it field by field.
// Depends on rtl/desa_pkg.sv.
`timescale 1ns / 100ps

module allocator_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [desa_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [1:0]                        op_i,
  input  logic                              side_i,
  input  logic [desa_pkg::AlignW-1:0]       align_i,
  input  logic [desa_pkg::SizeW-1:0]        size_i,
  input  logic                              done_i,
  input  logic                              ok_i,
  input  logic [31:0]                       address_i,
  input  logic [31:0]                       remaining_i,
  input  logic                              arena_empty_i,
  output int unsigned                       pending_o,
  output int unsigned                       errors_o
);

  localparam int unsigned MarkDepth  = desa_pkg::MarkerDepthDefault;
  localparam logic [63:0] OffsetMask = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned PrintCap   = 40;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [31:0] remaining;
    logic        arena_empty;
  } grant_t;

  grant_t grants_due[$];
  grant_t due;

  // mirrored registers
  logic [31:0]                  arena_q;
  logic [desa_pkg::HeaderW-1:0] header_q;
  logic [desa_pkg::MarkerW-1:0] marker_q;

  // mirrored arena state, indexed by side (0 left, 1 right)
  logic [63:0] used_q[2];
  logic [63:0] marks_q[2][MarkDepth];
  int unsigned depth_q[2];
  logic [63:0] free_bytes;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors_o < PrintCap)
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    errors_o++;
  endtask

  // both sides emptied, free space recomputed from the registers
  function automatic void clear_arena();
    used_q[0] = '0;
    used_q[1] = '0;
    depth_q[0] = 0;
    depth_q[1] = 0;
    free_bytes = (arena_q >= header_q) ? ((arena_q - header_q) & OffsetMask) : 64'd0;
  endfunction

  // power of two at or below a, minus one; 0 and 1 give no alignment
  function automatic logic [63:0] align_floor_mask(
      input logic [desa_pkg::AlignW-1:0] a);
    logic [63:0] p;
    p = 64'd1;
    while (p <= (a >> 1))
      p = p << 1;
    return p - 64'd1;
  endfunction

  // grant an aligned block on one side when the space covers size plus align - 1
  function automatic bit claim_block(input bit side,
                                     input logic [desa_pkg::AlignW-1:0] align,
                                     input logic [63:0] size, output logic [63:0] addr);
    logic [63:0] need, m, p, np, pad;
    addr = '0;
    need = size + ((align == '0) ? 64'd0 : (64'(align) - 64'd1));
    if (free_bytes < need)
      return 1'b0;
    m = align_floor_mask(align);
    if (!side) begin
      p   = (header_q + used_q[0]) & OffsetMask;
      np  = ((p + m) & ~m) & OffsetMask;
      pad = (np - p) & OffsetMask;
      used_q[0] = (used_q[0] + size + pad) & OffsetMask;
    end else begin
      p   = (arena_q - used_q[1] - size) & OffsetMask;
      np  = p & ~m;
      pad = p - np;
      used_q[1] = (used_q[1] + size + pad) & OffsetMask;
    end
    free_bytes = (free_bytes - size - pad) & OffsetMask;
    addr = np;
    return 1'b1;
  endfunction

  // one request against the mirrored state, giving the result it must produce
  function automatic grant_t apply_request(input logic [1:0] op, input bit side,
                                           input logic [desa_pkg::AlignW-1:0] align,
                                           input logic [desa_pkg::SizeW-1:0] size);
    grant_t      g;
    logic [63:0] addr, target, prior;
    bit          granted;
    addr    = '0;
    granted = 1'b0;
    case (op)
      desa_pkg::OpAlloc: begin
        granted = claim_block(side, align, 64'(size), addr);
      end
      desa_pkg::OpMark: begin
        if (depth_q[side] < MarkDepth) begin
          prior   = used_q[side];
          granted = claim_block(side, align, 64'(marker_q), addr);
          if (granted) begin
            marks_q[side][depth_q[side]] = prior;
            depth_q[side]++;
          end
        end
      end
      desa_pkg::OpRelease: begin
        // back to the last marker, or empty when there is none
        target = '0;
        if (depth_q[side] > 0) begin
          depth_q[side]--;
          target = marks_q[side][depth_q[side]];
        end
        if (target > used_q[side])
          target = used_q[side];
        free_bytes = (free_bytes + (used_q[side] - target)) & OffsetMask;
        used_q[side] = target;
        granted = 1'b1;
        addr = '0;
      end
      default: begin
        granted = 1'b0;
      end
    endcase
    g.ok          = granted;
    g.address     = granted ? addr[31:0] : 32'd0;
    g.remaining   = free_bytes[31:0];
    g.arena_empty = (used_q[0] == '0) && (used_q[1] == '0);
    return g;
  endfunction

  // register writes, item prediction and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grants_due.delete();
      arena_q  = desa_pkg::ArenaSizeReset;
      header_q = desa_pkg::HeaderBytesReset;
      marker_q = desa_pkg::MarkerBytesReset;
      clear_arena();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          desa_pkg::CfgArenaSize: begin
            arena_q = cfg_data_i;
            clear_arena();
          end
          desa_pkg::CfgHeaderBytes: begin
            header_q = cfg_data_i[desa_pkg::HeaderW-1:0];
            clear_arena();
          end
          desa_pkg::CfgMarkerBytes: begin
            marker_q = cfg_data_i[desa_pkg::MarkerW-1:0];
            clear_arena();
          end
          default: begin
          end
        endcase
      end
      if (start_i && !busy_i)
        grants_due.push_back(apply_request(op_i, side_i, align_i, size_i));
      if (done_i !== 1'b0) begin
        if (grants_due.size() == 0) begin
          report_mismatch("result with no item waiting", {31'd0, ok_i}, 32'd0);
        end else begin
          due = grants_due.pop_front();
          if (ok_i !== due.ok)
            report_mismatch("ok", {31'd0, ok_i}, {31'd0, due.ok});
          if (address_i !== due.address)
            report_mismatch("address", address_i, due.address);
          if (remaining_i !== due.remaining)
            report_mismatch("remaining", remaining_i, due.remaining);
          if (arena_empty_i !== due.arena_empty)
            report_mismatch("arena_empty", {31'd0, arena_empty_i}, {31'd0, due.arena_empty});
        end
      end
      pending_o = grants_due.size();
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the allocator bench: clock, reset, register phases and request stimulus.
// Depends on rtl/desa_pkg.sv, rtl/double_ended_stack_allocator.sv, bench/allocator_checker.sv.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0]                   OpUnused     = 2'd3;
  localparam logic [desa_pkg::CfgIdxW-1:0] CfgSpareIdx  = 2'd3;
  localparam int unsigned                  QuietLimit   = 500;
  localparam int unsigned                  SettleCycles = 8;
  localparam int unsigned                  PhaseCount   = 10;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [desa_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0]                  cfg_data_i;
  logic                         start_i;
  logic                         busy_o;
  logic [1:0]                   op_i;
  logic                         side_i;
  logic [desa_pkg::AlignW-1:0]  align_i;
  logic [desa_pkg::SizeW-1:0]   size_i;
  logic                         done_o;
  logic                         ok_o;
  logic [31:0]                  address_o;
  logic [31:0]                  remaining_o;
  logic                         arena_empty_o;

  int unsigned pending_items;
  int unsigned fail_count;

  bit          idling;
  logic [31:0] span;

  double_ended_stack_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .side_i        (side_i),
    .align_i       (align_i),
    .size_i        (size_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .address_o     (address_o),
    .remaining_o   (remaining_o),
    .arena_empty_o (arena_empty_o)
  );

  allocator_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .op_i          (op_i),
    .side_i        (side_i),
    .align_i       (align_i),
    .size_i        (size_i),
    .done_i        (done_o),
    .ok_i          (ok_o),
    .address_i     (address_o),
    .remaining_i   (remaining_o),
    .arena_empty_i (arena_empty_o),
    .pending_o     (pending_items),
    .errors_o      (fail_count)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one request item, after an optional idle burst; returns once accepted
  task automatic send(input logic [1:0] op, input logic side,
                      input logic [desa_pkg::AlignW-1:0] align,
                      input logic [desa_pkg::SizeW-1:0] size);
    int unsigned gap;
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 4);
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    op_i    <= op;
    side_i  <= side;
    align_i <= align;
    size_i  <= size;
    @(posedge clk_i);
    while (busy_o)
      @(posedge clk_i);
  endtask

  // hold off until every predicted result has come back
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_items != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [desa_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly small powers of two, sometimes none, huge or not a power of two
  function automatic logic [desa_pkg::AlignW-1:0] pick_align();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3)
      return desa_pkg::AlignW'($urandom_range(0, 1));
    else if (roll == 3)
      return desa_pkg::AlignW'($urandom_range(0, 17'h1FFFF));
    else if (roll == 4)
      return desa_pkg::AlignW'(1) << $urandom_range(7, 16);
    else
      return desa_pkg::AlignW'(1) << $urandom_range(1, 6);
  endfunction

  // sizes scaled to the free span of the current arena
  function automatic logic [desa_pkg::SizeW-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return '0;
    else if (roll == 1)
      return $urandom();
    else if (roll == 2)
      return $urandom_range(0, span);
    else
      return $urandom_range(0, (span >> 5) + 1);
  endfunction

  // scopes, marker storms, allocation runs and noise until count items are sent
  task automatic run_phase(input int unsigned count);
    int unsigned sent, roll, k, i;
    logic        s;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 19);
      s    = $urandom_range(0, 1);
      if (roll < 8) begin
        // mark, a few blocks, release back to the mark
        send(desa_pkg::OpMark, s, ($urandom_range(0, 2) == 0) ? pick_align() : '0,
             $urandom());
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++)
          send(desa_pkg::OpAlloc, ($urandom_range(0, 3) == 0) ? !s : s, pick_align(),
               pick_size());
        send(desa_pkg::OpRelease, s, desa_pkg::AlignW'($urandom_range(0, 17'h1FFFF)),
             $urandom());
        sent += k + 2;
      end else if (roll < 11) begin
        // marks that may fill a marker stack, then releases that may go past empty
        k = $urandom_range(10, 20);
        for (i = 0; i < k; i++)
          send(desa_pkg::OpMark, s, ($urandom_range(0, 3) == 0) ? pick_align() : '0,
               $urandom());
        roll = $urandom_range(1, k + 2);
        for (i = 0; i < roll; i++)
          send(desa_pkg::OpRelease, s, '0, $urandom());
        sent += k + roll;
      end else if (roll < 15) begin
        k = $urandom_range(3, 10);
        for (i = 0; i < k; i++)
          send(desa_pkg::OpAlloc, 1'($urandom_range(0, 1)), pick_align(), pick_size());
        sent += k;
      end else begin
        send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
             desa_pkg::AlignW'($urandom_range(0, 17'h1FFFF)), $urandom());
        sent += 1;
      end
      if ($urandom_range(0, 99) == 0)
        drain_results();
    end
  endtask

  // no item or result accepted for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [31:0]                  arena;
    logic [desa_pkg::HeaderW-1:0] hdr;
    logic [desa_pkg::MarkerW-1:0] mark;
    int unsigned                  phase;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    start_i     <= 1'b0;
    op_i        <= desa_pkg::OpAlloc;
    side_i      <= 1'b0;
    align_i     <= '0;
    size_i      <= '0;
    idling      = 1'b1;
    span        = desa_pkg::ArenaSizeReset - desa_pkg::HeaderBytesReset;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset arena
    send(desa_pkg::OpAlloc, 1'b0, 17'd0, 32'd0);
    send(desa_pkg::OpAlloc, 1'b0, 17'd3, 32'd5);
    send(desa_pkg::OpAlloc, 1'b0, 17'd65536, 32'd1);
    send(desa_pkg::OpAlloc, 1'b1, 17'd16, 32'd7);
    send(desa_pkg::OpMark, 1'b0, 17'd8, 32'hFFFF_FFFF);
    send(desa_pkg::OpAlloc, 1'b0, 17'd0, 32'd100);
    send(desa_pkg::OpRelease, 1'b0, 17'd0, 32'd0);
    send(desa_pkg::OpRelease, 1'b0, 17'h1FFFF, 32'd0);
    send(desa_pkg::OpRelease, 1'b1, 17'd0, 32'd0);
    send(OpUnused, 1'b1, 17'h1FFFF, 32'hFFFF_FFFF);
    send(desa_pkg::OpAlloc, 1'b1, 17'h1FFFF, 32'hFFFF_FFFF);
    send(desa_pkg::OpAlloc, 1'b0, 17'd1, span);
    send(desa_pkg::OpAlloc, 1'b1, 17'd0, 32'd0);
    send(desa_pkg::OpAlloc, 1'b1, 17'd2, 32'd0);
    send(desa_pkg::OpMark, 1'b1, 17'd0, 32'd0);
    send(desa_pkg::OpRelease, 1'b1, 17'd0, 32'd0);
    send(desa_pkg::OpRelease, 1'b0, 17'd0, 32'd0);
    run_phase(60);

    // register phases: fixed extremes first, then random arenas
    for (phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      if (phase == 1)
        write_reg(CfgSpareIdx, $urandom());
      case (phase)
        0: begin
          arena = 32'd4096;
          hdr   = '0;
          mark  = 7'd1;
        end
        1: begin
          arena = 32'hFFFF_FFFF;
          hdr   = 13'd4096;
          mark  = 7'd64;
        end
        2: begin
          arena = 32'd100;
          hdr   = 13'd200;
          mark  = 7'd16;
        end
        3: begin
          arena = 32'd0;
          hdr   = '0;
          mark  = 7'd1;
        end
        default: begin
          arena = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(256, 20000);
          hdr   = desa_pkg::HeaderW'($urandom_range(0, 1024));
          mark  = desa_pkg::MarkerW'($urandom_range(1, 64));
        end
      endcase
      write_reg(desa_pkg::CfgArenaSize, arena);
      write_reg(desa_pkg::CfgHeaderBytes, 32'(hdr));
      write_reg(desa_pkg::CfgMarkerBytes, 32'(mark));
      span   = (arena > hdr) ? (arena - hdr) : 32'd1;
      idling = (phase != PhaseCount - 1);
      run_phase((phase == 2 || phase == 3) ? 40 : 180);
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
